@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the Huffman bit packer.
// Depends on nothing; each macro expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ src/hcbp_pkg.sv @@
// Shared constants, request codes and codebook types of the Huffman bit packer.
// Depends on nothing; used by hcbp_codebook and huffman_code_bit_packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int WORD_BITS    = 16;
  localparam int SYM_W        = 8;
  localparam int LEN_W        = 5;
  localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
  localparam int FILL_W       = $clog2(WORD_BITS);
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 16;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] code;
  } cb_entry_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
  } cb_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } cb_rd_t;

endpackage

`default_nettype wire

@@ src/hcbp_codebook.sv @@
// Codebook memory: one entry per symbol, written by load requests.
// Depends on hcbp_pkg. Read data is registered and appears in the cycle after the read enable.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_codebook (
  input  wire                  clk,
  input  hcbp_pkg::cb_wr_t     wr,
  input  hcbp_pkg::cb_rd_t     rd,
  output hcbp_pkg::cb_entry_t  rd_data
);

  hcbp_pkg::cb_entry_t mem [hcbp_pkg::SYMBOL_COUNT];
  hcbp_pkg::cb_entry_t rd_data_r;
  hcbp_pkg::cb_entry_t wr_entry;

  logic [hcbp_pkg::LEN_W-1:0]     len_sat;
  logic [hcbp_pkg::WORD_BITS:0]   mask_w;

  // Lengths beyond a full word saturate, and code bits above the length are dropped.
  always_comb begin
    if (wr.len > hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS)) begin
      len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS);
    end else begin
      len_sat = wr.len;
    end
    mask_w        = ((hcbp_pkg::WORD_BITS+1)'(1) << len_sat) - (hcbp_pkg::WORD_BITS+1)'(1);
    wr_entry.len  = len_sat;
    wr_entry.code = wr.code & mask_w[hcbp_pkg::WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ src/huffman_code_bit_packer.sv @@
// Top level of the Huffman bit packer: request intake, word accumulator and output register.
// Depends on hcbp_pkg, hcbp_codebook and assert_macros.svh.
//
//   Channel  Direction  Handshake           Payload
//   in_      slave      tvalid/tready       tuser: req_type; tdata: symbol, code, length
//   out_     master     tvalid/tready       tdata: packed_word; tlast: is_final
//
// One request per cycle is accepted while the packing stage is empty or firing. A load writes
// the codebook at its accept edge; an encode reads it into the codebook read register at that
// edge, the packing stage then merges the code, and a word it fills is registered onto out_.
// Reset clears the accumulator, the fill count and the valid flags, not the codebook.
// A stalled result holds the packing stage only when that stage also has a word to send.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module huffman_code_bit_packer (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [hcbp_pkg::IN_DATA_W-1:0]    in_tdata,   // symbol[7:0], code_value[23:8], code_length[28:24]
  input  wire [1:0]                        in_tuser,   // req_type[1:0]
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [hcbp_pkg::OUT_DATA_W-1:0]  out_tdata,  // packed_word[15:0]
  output logic                             out_tlast
);

  localparam int WB = hcbp_pkg::WORD_BITS;

  hcbp_pkg::req_type_t            req;
  logic [hcbp_pkg::SYM_W-1:0]     sym;
  logic                           sym_ok;
  logic                           in_acc;
  logic                           to_s1;

  hcbp_pkg::cb_wr_t               cb_wr;
  hcbp_pkg::cb_rd_t               cb_rd;
  hcbp_pkg::cb_entry_t            cb_q;

  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_flush_r;
  logic                           s1_emit;
  logic                           s1_fire;
  logic                           out_free;

  logic [WB-1:0]                  acc_r, acc_nxt;
  logic [hcbp_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic [WB-1:0]                  acc_or;
  logic [hcbp_pkg::FILL_W+1:0]    total;
  logic [hcbp_pkg::FILL_W+1:0]    rest;
  logic [hcbp_pkg::LEN_W-1:0]     shamt;

  logic                           out_tvalid_r;
  logic [WB-1:0]                  out_tdata_r;
  logic                           out_tlast_r;

  assign req    = hcbp_pkg::req_type_t'(in_tuser);
  assign sym    = in_tdata[hcbp_pkg::SYM_W-1:0];
  assign sym_ok = {1'b0, sym} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::SYMBOL_COUNT);
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    cb_wr.en   = in_acc && (req == hcbp_pkg::REQ_LOAD) && sym_ok;
    cb_wr.addr = sym[hcbp_pkg::ADDR_W-1:0];
    cb_wr.code = in_tdata[hcbp_pkg::SYM_W +: WB];
    cb_wr.len  = in_tdata[hcbp_pkg::SYM_W+WB +: hcbp_pkg::LEN_W];
    cb_rd.en   = in_acc && (req == hcbp_pkg::REQ_ENCODE) && sym_ok;
    cb_rd.addr = sym[hcbp_pkg::ADDR_W-1:0];
  end

  // A load and an encode are never accepted in the same cycle, so the read
  // of an encode always sees every load accepted before it.
  hcbp_codebook u_codebook (
    .clk     (clk),
    .wr      (cb_wr),
    .rd      (cb_rd),
    .rd_data (cb_q)
  );

  always_comb begin
    case (req)
      hcbp_pkg::REQ_ENCODE: to_s1 = sym_ok;
      hcbp_pkg::REQ_FLUSH:  to_s1 = 1'b1;
      default:              to_s1 = 1'b0;
    endcase
  end

  // Packing stage: merge the looked-up code above the filled bits, or clear them on a flush.
  always_comb begin
    total  = (hcbp_pkg::FILL_W+2)'(fill_r) + (hcbp_pkg::FILL_W+2)'(cb_q.len);
    acc_or = acc_r | (cb_q.code << fill_r);
    rest   = total - (hcbp_pkg::FILL_W+2)'(WB);
    shamt  = cb_q.len - hcbp_pkg::LEN_W'(rest);
    s1_emit = s1_flush_r || (total >= (hcbp_pkg::FILL_W+2)'(WB));

    if (s1_flush_r) begin
      acc_nxt  = '0;
      fill_nxt = '0;
    end else if (s1_emit) begin
      acc_nxt  = cb_q.code >> shamt;
      fill_nxt = rest[hcbp_pkg::FILL_W-1:0];
    end else begin
      acc_nxt  = acc_or;
      fill_nxt = total[hcbp_pkg::FILL_W-1:0];
    end
  end

  assign out_free  = !out_tvalid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_emit || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  always_comb begin
    if (in_acc && to_s1) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
      fill_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_fire) begin
        acc_r  <= acc_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && to_s1) begin
      s1_flush_r <= (req == hcbp_pkg::REQ_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_tdata_r <= s1_flush_r ? acc_r : acc_or;
      out_tlast_r <= s1_flush_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `ASSERT_CLK(a_flush_clears, (s1_fire && s1_flush_r) |=> (acc_r == '0 && fill_r == '0), "flush left bits in the accumulator")
  `ASSERT_CLK(a_emit_shows, (s1_fire && s1_emit) |=> out_tvalid, "emitted word did not reach the output register")
  `ASSERT_ALWAYS(a_ready_when_empty, (s1_valid_r || in_tready), "input stalled with an empty packing stage")

endmodule

`default_nettype wire

@@ sim/tb_huffman_code_bit_packer.sv @@
// Self-checking testbench for huffman_code_bit_packer: loads codebooks, encodes symbol
// streams and flushes, predicting every packed word and comparing it on the out_ channel.
// Depends on hcbp_pkg and the RTL of the bit packer; needs no files or arguments.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 630;

  typedef struct packed {
    logic [hcbp_pkg::WORD_BITS-1:0] word;
    logic                           last;
  } packed_word_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hcbp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hcbp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // Predicted state of the packer.
  logic [hcbp_pkg::WORD_BITS-1:0] book_code [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::LEN_W-1:0]     book_len [hcbp_pkg::SYMBOL_COUNT];
  bit                             book_written [hcbp_pkg::SYMBOL_COUNT];
  logic [7:0]                     loaded_syms [$];
  logic [hcbp_pkg::WORD_BITS-1:0] acc_word = '0;
  logic [hcbp_pkg::LEN_W-1:0]     acc_fill = '0;
  packed_word_t                   expected_words [$];

  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned n_loads = 0, n_encodes = 0, n_flushes = 0, n_ignored = 0;
  int          burst_left = 0;
  bit          sender_active = 1'b0;
  int          idle_cycles = 0;
  rx_mode_t    rx_mode = RX_STEADY;
  int          rx_count = 0;

  huffman_code_bit_packer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Applies one accepted request to the predicted state and queues any word it yields.
  function automatic void pack_predict(input logic [1:0] req, input logic [7:0] sym,
                                       input logic [15:0] cval, input logic [4:0] clen);
    logic [hcbp_pkg::LEN_W-1:0]     len;
    logic [hcbp_pkg::WORD_BITS-1:0] code;
    logic [5:0]                     total;
    logic [31:0]                    wide;
    case (req)
      hcbp_pkg::REQ_LOAD: begin
        len = (clen > hcbp_pkg::WORD_BITS) ?
              hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS) : clen;
        code = cval;
        if (len < hcbp_pkg::WORD_BITS) code = cval & ((16'd1 << len) - 16'd1);
        book_code[sym] = code;
        book_len[sym] = len;
        if (!book_written[sym]) loaded_syms.push_back(sym);
        book_written[sym] = 1'b1;
        n_loads++;
      end
      hcbp_pkg::REQ_ENCODE: begin
        code = book_code[sym];
        len = book_len[sym];
        total = {1'b0, acc_fill} + {1'b0, len};
        wide = {16'd0, code} << acc_fill;
        acc_word = acc_word | wide[15:0];
        if (total >= hcbp_pkg::WORD_BITS) begin
          // The bits that did not fit start the next word.
          expected_words.push_back('{word: acc_word, last: 1'b0});
          acc_word = wide[31:16];
          acc_fill = hcbp_pkg::LEN_W'(total - hcbp_pkg::WORD_BITS);
        end else begin
          acc_fill = total[hcbp_pkg::LEN_W-1:0];
        end
        n_encodes++;
      end
      hcbp_pkg::REQ_FLUSH: begin
        expected_words.push_back('{word: acc_word, last: 1'b1});
        acc_word = '0;
        acc_fill = '0;
        n_flushes++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Sends one beat; the sender runs in bursts separated by idle gaps.
  task automatic send_req(input logic [1:0] req, input logic [7:0] sym,
                          input logic [15:0] cval, input logic [4:0] clen);
    if (burst_left == 0) begin
      if (sender_active) in_tvalid <= 1'b0;
      sender_active = 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {3'b000, clen, cval, sym};
    sender_active = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pack_predict(req, sym, cval, clen);
    burst_left--;
  endtask

  task automatic stream_idle();
    if (sender_active) in_tvalid <= 1'b0;
    sender_active = 1'b0;
    burst_left = 0;
  endtask

  task automatic send_encode_random();
    send_req(hcbp_pkg::REQ_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
             16'($urandom), 5'($urandom));
  endtask

  task automatic send_load_random();
    logic [4:0] clen;
    // Mostly legal lengths; now and then zero or an oversized length.
    if ($urandom_range(0, 9) == 0)
      clen = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
    else if ($urandom_range(0, 3) == 0)
      clen = 5'($urandom_range(12, 16));
    else
      clen = 5'($urandom_range(1, 8));
    send_req(hcbp_pkg::REQ_LOAD, 8'($urandom_range(0, 255)), 16'($urandom), clen);
  endtask

  // Extremes of every field, each request type, and the corner cases of the codebook.
  task automatic test_directed();
    send_req(hcbp_pkg::REQ_LOAD, 8'd0, 16'hFFFF, 5'd16);
    send_req(hcbp_pkg::REQ_LOAD, 8'd255, 16'h0001, 5'd1);
    send_req(hcbp_pkg::REQ_LOAD, 8'd1, 16'hABCD, 5'd0);    // zero length adds nothing
    send_req(hcbp_pkg::REQ_LOAD, 8'd2, 16'h5A5A, 5'd31);   // saturates to sixteen bits
    send_req(hcbp_pkg::REQ_LOAD, 8'd3, 16'hFFFF, 5'd3);    // bits above the length are dropped
    send_req(hcbp_pkg::REQ_LOAD, 8'd4, 16'h0000, 5'd5);
    send_req(hcbp_pkg::REQ_LOAD, 8'd5, 16'hFE01, 5'd9);
    send_req(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);  // empty final word
    send_req(hcbp_pkg::REQ_ENCODE, 8'd255, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_FLUSH, 8'hFF, 16'hFFFF, 5'd31);
    send_req(hcbp_pkg::REQ_ENCODE, 8'd0, 16'h0000, 5'd0);  // fills a word exactly
    send_req(hcbp_pkg::REQ_ENCODE, 8'd3, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_ENCODE, 8'd0, 16'h0000, 5'd0);  // spills into the next word
    send_req(hcbp_pkg::REQ_ENCODE, 8'd1, 16'h0000, 5'd0);
    send_req(REQ_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
    send_req(hcbp_pkg::REQ_ENCODE, 8'd4, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_ENCODE, 8'd2, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_ENCODE, 8'd5, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_ENCODE, 8'd5, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
    send_req(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
    stream_idle();
  endtask

  // Messages: an optional codebook update, a run of encodes, then usually a flush.
  // A few noise beats (unused type, stray loads) fall inside the runs.
  task automatic test_message_stream(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      repeat ((loaded_syms.size() < 8) ? $urandom_range(4, 10) : $urandom_range(0, 3)) begin
        send_load_random();
        sent++;
      end
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
      repeat (run_len) begin
        case ($urandom_range(0, 39))
          0: send_req(REQ_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom));
          1: begin
            send_load_random();
            sent++;
          end
          default: begin
            send_encode_random();
            sent++;
          end
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        send_req(hcbp_pkg::REQ_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
        sent++;
      end
    end
    send_req(hcbp_pkg::REQ_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
    stream_idle();
  endtask

  // Receiver backpressure switches among four modes at random intervals.
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_count <= $urandom_range(20, 80);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      RX_STEADY: out_tready <= 1'b1;
      RX_LIGHT:  out_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:  out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= (rx_count % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    packed_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== want.word)
          report_mismatch($sformatf("packed word %h, expected %h", out_tdata, want.word));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("final flag %b, expected %b (word %h)",
                                    out_tlast, want.last, want.word));
      end
      words_checked++;
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d words outstanding",
               IDLE_LIMIT, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_message_stream(RANDOM_ITEMS);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d loads, %0d encodes, %0d flushes and %0d ignored beats;",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("%0d packed words compared, %0d mismatches.", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
